/* rtl/rggs_pkg.sv */
// ----------------------------------------------------------------------------
// rggs_pkg: shared types and constants of the rotation gradient gather-sum
// Sizes of the index table and gradient buffer, command codes, the queued
// command word and the limits that the front hands to the back.
// ----------------------------------------------------------------------------
package rggs_pkg;

  // Store geometry.
  localparam int MAX_ENTRIES   = 256;
  localparam int MAX_ROTATIONS = 8;
  localparam int ROT_SLOTS     = 8;
  localparam int ROT_LIMIT     = (MAX_ROTATIONS < ROT_SLOTS) ? MAX_ROTATIONS : ROT_SLOTS;

  // Field widths.
  localparam int ENT_W    = 8;
  localparam int ROT_W    = 3;
  localparam int IDX_W    = 8;
  localparam int GRAD_W   = 32;
  localparam int SUM_W    = GRAD_W + $clog2(ROT_SLOTS);
  localparam int ECNT_W   = 9;
  localparam int RCNT_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // Memory depths and address widths.
  localparam int TABLE_DEPTH = MAX_ENTRIES * MAX_ROTATIONS;
  localparam int ADDR_W      = ENT_W + ROT_W;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_COUNT = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [ECNT_W-1:0] ENTRY_COUNT_RST    = 9'd72;
  localparam logic [RCNT_W-1:0] ROTATION_COUNT_RST = 4'd8;

  // Command codes carried on the func field.
  typedef enum logic [1:0] {
    FUNC_LOAD_INDEX = 2'd0,
    FUNC_STORE_GRAD = 2'd1,
    FUNC_QUERY      = 2'd2
  } func_e;

  // One classified command word in the queue.
  typedef struct packed {
    func_e                     op;
    logic [ENT_W-1:0]          ent;
    logic [ROT_W-1:0]          rot;
    logic [IDX_W-1:0]          idx;
    logic signed [GRAD_W-1:0]  grad;
    logic                      ent_bad;
  } cmd_t;

  // Saturated limits taken from the configuration registers.
  typedef struct packed {
    logic [ECNT_W-1:0] n_ent;
    logic [RCNT_W-1:0] n_rot;
  } limits_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN,
    BK_DONE
  } bstate_e;

endpackage

/* rtl/rggs_front.sv */
// ----------------------------------------------------------------------------
// rggs_front: input acceptance and command classification
// Holds the configuration registers, accepts input words while the queue has
// room, drops unused codes and flags queries of entries out of range.
// ----------------------------------------------------------------------------
module rggs_front
  import rggs_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                func_i,
  input  logic [ENT_W-1:0]          entry_slot_i,
  input  logic [ROT_W-1:0]          rotation_slot_i,
  input  logic [IDX_W-1:0]          index_byte_i,
  input  logic signed [GRAD_W-1:0]  grad_value_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output cmd_t                      cmd_o,
  output limits_t                   limits_o
);

  logic [ECNT_W-1:0] entry_count_q;
  logic [RCNT_W-1:0] rotation_count_q;
  logic              known_func;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q    <= ENTRY_COUNT_RST;
      rotation_count_q <= ROTATION_COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ENTRY_COUNT:    entry_count_q    <= cfg_data_i[ECNT_W-1:0];
        CFG_ROTATION_COUNT: rotation_count_q <= cfg_data_i[RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate both counts to what the stores can hold.
  always_comb begin
    limits_o.n_ent = (entry_count_q > ECNT_W'(MAX_ENTRIES)) ?
                     ECNT_W'(MAX_ENTRIES) : entry_count_q;
    limits_o.n_rot = (rotation_count_q > RCNT_W'(ROT_LIMIT)) ?
                     RCNT_W'(ROT_LIMIT) : rotation_count_q;
  end

  // Accept while the queue has room; the unused code is dropped here.
  assign in_ready_o = !q_full_i;
  assign known_func = (func_i == FUNC_LOAD_INDEX) || (func_i == FUNC_STORE_GRAD) ||
                      (func_i == FUNC_QUERY);
  assign push_o     = in_valid_i && in_ready_o && known_func;

  // Build the command word.
  always_comb begin
    cmd_o.op      = func_e'(func_i);
    cmd_o.ent     = entry_slot_i;
    cmd_o.rot     = rotation_slot_i;
    cmd_o.idx     = index_byte_i;
    cmd_o.grad    = grad_value_i;
    cmd_o.ent_bad = ({1'b0, entry_slot_i} >= limits_o.n_ent);
  end

endmodule

/* rtl/rggs_queue.sv */
// ----------------------------------------------------------------------------
// rggs_queue: short command queue between front and back
// A small circular buffer of command words with full and empty flags.
// ----------------------------------------------------------------------------
module rggs_queue
  import rggs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cmd_t  cmd_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output cmd_t  head_o
);

  cmd_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= count_q + QCNT_W'(1);
      else if (pop_i && !push_i) count_q <= count_q - QCNT_W'(1);
    end
  end

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= cmd_i;
  end

endmodule

/* rtl/rggs_back.sv */
// ----------------------------------------------------------------------------
// rggs_back: command execution over the index table and gradient buffer
// Writes load words into the single-port stores and runs queries as a short
// pipeline: table read, range check with buffer read, then accumulate.
// ----------------------------------------------------------------------------
module rggs_back
  import rggs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  limits_t                  limits_i,
  input  logic                     q_empty_i,
  input  cmd_t                     head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [SUM_W-1:0]  grad_sum_o,
  output logic [ENT_W-1:0]         query_entry_o,
  output logic                     index_fault_o
);

  bstate_e state_q, state_d;

  // Stores.
  logic [IDX_W-1:0]  idx_mem  [TABLE_DEPTH];
  logic [GRAD_W-1:0] grad_mem [TABLE_DEPTH];
  logic [IDX_W-1:0]  idx_rdata_q;
  logic [GRAD_W-1:0] grad_rdata_q;
  logic [ADDR_W-1:0] idx_addr, grad_addr;
  logic              idx_we, grad_we;

  // Query sequencing.
  logic                     issue, start, finish, last_issue;
  logic [RCNT_W-1:0]        k_q;
  logic [ENT_W-1:0]         qry_ent_q;
  logic                     s1_valid_q, s1_last_q;
  logic [ROT_W-1:0]         s1_rot_q;
  logic                     s2_use_q, s2_last_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic                     fault_q;
  logic                     pos_ok;
  logic [IDX_W-1:0]         pos_m1;
  logic                     out_valid_q;

  // Range check on the table byte of the word in stage one.
  assign pos_ok     = (idx_rdata_q != '0) && ({1'b0, idx_rdata_q} <= limits_i.n_ent);
  assign pos_m1     = idx_rdata_q - IDX_W'(1);
  assign last_issue = (k_q == limits_i.n_rot - RCNT_W'(1));

  // Sequencer: next state, store controls and addresses.
  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    idx_we    = 1'b0;
    grad_we   = 1'b0;
    issue     = 1'b0;
    start     = 1'b0;
    finish    = 1'b0;
    idx_addr  = {head_i.ent, head_i.rot};
    grad_addr = {head_i.rot, head_i.ent};
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          case (head_i.op)
            FUNC_LOAD_INDEX: idx_we = 1'b1;
            FUNC_STORE_GRAD: grad_we = 1'b1;
            FUNC_QUERY: begin
              start   = 1'b1;
              state_d = (head_i.ent_bad || (limits_i.n_rot == '0)) ? BK_DONE : BK_RUN;
            end
            default: ;
          endcase
        end
      end
      BK_RUN: begin
        issue     = 1'b1;
        idx_addr  = {qry_ent_q, k_q[ROT_W-1:0]};
        grad_addr = {s1_rot_q, pos_m1};
        if (last_issue) state_d = BK_DRAIN;
      end
      BK_DRAIN: begin
        grad_addr = {s1_rot_q, pos_m1};
        if (s2_last_q) state_d = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          finish  = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Index table port.
  always_ff @(posedge clk_i) begin
    if (idx_we) idx_mem[idx_addr] <= head_i.idx;
    idx_rdata_q <= idx_mem[idx_addr];
  end

  // Gradient buffer port.
  always_ff @(posedge clk_i) begin
    if (grad_we) grad_mem[grad_addr] <= head_i.grad;
    grad_rdata_q <= grad_mem[grad_addr];
  end

  // Control state and pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_use_q    <= 1'b0;
      s2_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= issue;
      s1_last_q  <= issue && last_issue;
      s2_use_q   <= s1_valid_q && pos_ok;
      s2_last_q  <= s1_valid_q && s1_last_q;
      if (start)      k_q <= '0;
      else if (issue) k_q <= k_q + RCNT_W'(1);
      if (finish)           out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Accumulator and result register.
  always_ff @(posedge clk_i) begin
    if (issue) s1_rot_q <= k_q[ROT_W-1:0];
    if (start) begin
      sum_q     <= '0;
      fault_q   <= head_i.ent_bad;
      qry_ent_q <= head_i.ent;
    end else begin
      if (s2_use_q) begin
        sum_q <= sum_q + {{(SUM_W-GRAD_W){grad_rdata_q[GRAD_W-1]}}, grad_rdata_q};
      end
      if (s1_valid_q && !pos_ok) fault_q <= 1'b1;
    end
    if (finish) begin
      grad_sum_o    <= sum_q;
      query_entry_o <= qry_ent_q;
      index_fault_o <= fault_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/rotation_gradient_gather_sum.sv */
// ----------------------------------------------------------------------------
// rotation_gradient_gather_sum: gradient alignment for rotated filter copies
// Gathers and sums gradients of all active rotations of one filter entry
// through a per-entry index table, in Q19.16.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                          | Direction
//  --------+--------------------------------------------------+----------
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i   | in
//  in      | in_valid_i in_ready_o func_i entry_slot_i        | in
//          | rotation_slot_i index_byte_i grad_value_i        |
//  out     | out_valid_o out_ready_i grad_sum_o query_entry_o | out
//          | index_fault_o                                    |
//
// A table load or gradient store is written in the back end as it is popped. A
// query passes through a dispatch step, one table read per rotation on the
// single-port index table, a drain of the buffer read and the accumulate, and
// a done step that loads the result register. A query of an entry out of
// range, or with no rotations, goes from dispatch straight to the done step.
// Reset clears control state only; the stores hold nothing defined until
// written. A stalled result only holds the back end once the next query is
// ready to deliver; the queue keeps taking words meanwhile.
// ----------------------------------------------------------------------------
module rotation_gradient_gather_sum
  import rggs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               func_i,
  input  logic [ENT_W-1:0]         entry_slot_i,
  input  logic [ROT_W-1:0]         rotation_slot_i,
  input  logic [IDX_W-1:0]         index_byte_i,
  input  logic signed [GRAD_W-1:0] grad_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [SUM_W-1:0]  grad_sum_o,
  output logic [ENT_W-1:0]         query_entry_o,
  output logic                     index_fault_o
);

  logic    push, pop, q_full, q_empty;
  cmd_t    cmd, head;
  limits_t limits;

  // Front end: configuration, acceptance and classification.
  rggs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .entry_slot_i    (entry_slot_i),
    .rotation_slot_i (rotation_slot_i),
    .index_byte_i    (index_byte_i),
    .grad_value_i    (grad_value_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .cmd_o           (cmd),
    .limits_o        (limits)
  );

  // Command queue.
  rggs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  // Back end: stores, query pipeline and result register.
  rggs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .limits_i      (limits),
    .q_empty_i     (q_empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .grad_sum_o    (grad_sum_o),
    .query_entry_o (query_entry_o),
    .index_fault_o (index_fault_o)
  );

  // The back end never takes a word from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("command popped from an empty queue");

  // The front end never writes into a full queue.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("command pushed into a full queue");

  // A pushed word makes the queue non-empty on the next cycle.
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !q_empty)
    else $error("pushed command not visible in the queue");

endmodule

/* tb/sv/tb_rotation_gradient_gather_sum.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotation_gradient_gather_sum: self-checking bench of the gather-sum
// Loads index table words and gradient words, then queries summed entries
// over a range of entry and rotation counts. Every query result is compared
// with a shadow predictor of both stores, under random idling on both sides
// and one long result stall.
// ----------------------------------------------------------------------------
module tb_rotation_gradient_gather_sum
  import rggs_pkg::*;
;

  // Unused command code, which the block drops without a result.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Quiet cycles allowed before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  // Cycles that let trailing loads and stores retire before idle work.
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [SUM_W-1:0] grad_sum;
    logic [ENT_W-1:0]        query_entry;
    logic                    index_fault;
  } gather_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               func_i = '0;
  logic [ENT_W-1:0]         entry_slot_i = '0;
  logic [ROT_W-1:0]         rotation_slot_i = '0;
  logic [IDX_W-1:0]         index_byte_i = '0;
  logic signed [GRAD_W-1:0] grad_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [SUM_W-1:0]  grad_sum_o;
  logic [ENT_W-1:0]         query_entry_o;
  logic                     index_fault_o;

  rotation_gradient_gather_sum dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .entry_slot_i   (entry_slot_i),
    .rotation_slot_i(rotation_slot_i),
    .index_byte_i   (index_byte_i),
    .grad_value_i   (grad_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .grad_sum_o     (grad_sum_o),
    .query_entry_o  (query_entry_o),
    .index_fault_o  (index_fault_o)
  );

  // Shadow copies of both stores, with flags of what has been written.
  logic [IDX_W-1:0]         index_shadow [MAX_ENTRIES][MAX_ROTATIONS];
  bit                       index_known  [MAX_ENTRIES][MAX_ROTATIONS];
  logic signed [GRAD_W-1:0] grad_shadow  [MAX_ROTATIONS][MAX_ENTRIES];
  bit                       grad_known   [MAX_ROTATIONS][MAX_ENTRIES];

  logic [ECNT_W-1:0] entry_count_q    = ENTRY_COUNT_RST;
  logic [RCNT_W-1:0] rotation_count_q = ROTATION_COUNT_RST;

  gather_t sums_due [$];
  int      error_count = 0;
  int      words_sent = 0;
  int      quiet_cycles = 0;
  int      hold_req = 0;
  bit      calm = 1'b0;

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_entries();
    return (entry_count_q > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_count_q);
  endfunction

  function automatic int eff_rotations();
    return (rotation_count_q > ROT_LIMIT) ? ROT_LIMIT : int'(rotation_count_q);
  endfunction

  // Sum of the gathered gradients of one entry, as the block should give it.
  function automatic gather_t predict_gather(input logic [ENT_W-1:0] ent);
    gather_t          g;
    int               n_ent;
    int               n_rot;
    logic [IDX_W-1:0] pos;
    logic [GRAD_W-1:0] w;
    g.grad_sum    = '0;
    g.query_entry = ent;
    g.index_fault = 1'b0;
    n_ent = eff_entries();
    n_rot = eff_rotations();
    if (ent >= n_ent) begin
      g.index_fault = 1'b1;
    end else begin
      for (int k = 0; k < n_rot; k++) begin
        pos = index_shadow[ent][ROT_W'(k)];
        if (pos == 0 || pos > n_ent) begin
          g.index_fault = 1'b1;
        end else begin
          w = grad_shadow[ROT_W'(k)][ENT_W'(pos - 1)];
          g.grad_sum = g.grad_sum + {{(SUM_W - GRAD_W){w[GRAD_W-1]}}, w};
        end
      end
    end
    return g;
  endfunction

  // True when a query of this entry reads only words written before.
  function automatic bit reads_defined(input logic [ENT_W-1:0] ent);
    int               n_ent;
    logic [IDX_W-1:0] pos;
    n_ent = eff_entries();
    if (ent >= n_ent) return 1'b1;
    for (int k = 0; k < eff_rotations(); k++) begin
      if (!index_known[ent][ROT_W'(k)]) return 1'b0;
      pos = index_shadow[ent][ROT_W'(k)];
      if (pos != 0 && pos <= n_ent && !grad_known[ROT_W'(k)][ENT_W'(pos - 1)])
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [GRAD_W-1:0] rand_grad();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Offers one word on the input channel and updates the shadow on accept.
  // Valid stays high afterwards; a gap before the next word or an idle step lowers it.
  task automatic issue_word(input logic [1:0] func, input logic [ENT_W-1:0] ent,
                            input logic [ROT_W-1:0] rot, input logic [IDX_W-1:0] idx,
                            input logic signed [GRAD_W-1:0] grad);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= func;
    entry_slot_i    <= ent;
    rotation_slot_i <= rot;
    index_byte_i    <= idx;
    grad_value_i    <= grad;
    do @(posedge clk_i); while (!in_ready_o);
    case (func)
      FUNC_LOAD_INDEX: begin
        index_shadow[ent][rot] = idx;
        index_known[ent][rot]  = 1'b1;
      end
      FUNC_STORE_GRAD: begin
        grad_shadow[rot][ent] = grad;
        grad_known[rot][ent]  = 1'b1;
      end
      FUNC_QUERY: sums_due.push_back(predict_gather(ent));
      default: ;
    endcase
    if (func != FUNC_UNUSED) words_sent++;
  endtask

  // Waits until every expected sum has come and the back end has gone quiet.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_ENTRY_COUNT) entry_count_q = data;
    else rotation_count_q = data[RCNT_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] ecnt,
                               input logic [CFG_DATA_W-1:0] rdata);
    settle_block();
    write_register(CFG_ENTRY_COUNT, ecnt);
    write_register(CFG_ROTATION_COUNT, rdata);
  endtask

  // Well-formed sequence: fill the table row of an entry, store the words it
  // points at, then query it. Faulty positions are mixed in now and then.
  task automatic gather_sequence(input logic [ENT_W-1:0] ent);
    int               n_ent;
    int               n_rot;
    logic [IDX_W-1:0] pos;
    n_ent = eff_entries();
    n_rot = eff_rotations();
    if (ent < n_ent) begin
      for (int k = 0; k < n_rot; k++) begin
        if (!index_known[ent][ROT_W'(k)] || $urandom_range(0, 1) == 0) begin
          if ($urandom_range(0, 5) == 0) begin
            if (n_ent >= 255 || $urandom_range(0, 1) == 0) pos = '0;
            else pos = IDX_W'($urandom_range(n_ent + 1, 255));
          end else begin
            // A table byte reaches position 255 at most.
            pos = IDX_W'($urandom_range(1, (n_ent > 255) ? 255 : n_ent));
          end
          issue_word(FUNC_LOAD_INDEX, ent, ROT_W'(k), pos, rand_grad());
        end
      end
      for (int k = 0; k < n_rot; k++) begin
        pos = index_shadow[ent][ROT_W'(k)];
        if (pos != 0 && pos <= n_ent &&
            (!grad_known[ROT_W'(k)][ENT_W'(pos - 1)] || $urandom_range(0, 1) == 0))
          issue_word(FUNC_STORE_GRAD, ENT_W'(pos - 1), ROT_W'(k), IDX_W'($urandom),
                     rand_grad());
      end
    end
    issue_word(FUNC_QUERY, ent, ROT_W'($urandom), IDX_W'($urandom), $urandom);
  endtask

  // Mixed traffic: mostly well-formed sequences, the rest repeat queries,
  // stray loads and stores and unused codes.
  task automatic random_burst(input int count);
    int               target;
    int               pick;
    int               n_ent;
    logic [ENT_W-1:0] ent;
    target = words_sent + count;
    while (words_sent < target) begin
      pick  = $urandom_range(0, 99);
      n_ent = eff_entries();
      if (n_ent > 0 && $urandom_range(0, 6) != 0) ent = ENT_W'($urandom_range(0, n_ent - 1));
      else ent = ENT_W'($urandom);
      if (pick < 60) begin
        gather_sequence(ent);
      end else if (pick < 72) begin
        if (reads_defined(ent))
          issue_word(FUNC_QUERY, ent, ROT_W'($urandom), IDX_W'($urandom), $urandom);
        else gather_sequence(ent);
      end else if (pick < 85) begin
        issue_word(FUNC_LOAD_INDEX, ENT_W'($urandom), ROT_W'($urandom), IDX_W'($urandom),
                   rand_grad());
      end else if (pick < 96) begin
        issue_word(FUNC_STORE_GRAD, ENT_W'($urandom), ROT_W'($urandom), IDX_W'($urandom),
                   rand_grad());
      end else begin
        issue_word(FUNC_UNUSED, ENT_W'($urandom), ROT_W'($urandom), IDX_W'($urandom),
                   rand_grad());
      end
    end
  endtask

  // Reset settings: extreme sums, faulty positions, unused code, bad entries.
  task automatic test_directed_basics();
    for (int k = 0; k < 8; k++)
      issue_word(FUNC_STORE_GRAD, 8'd0, ROT_W'(k), 8'd0, 32'sh8000_0000);
    for (int k = 0; k < 8; k++)
      issue_word(FUNC_LOAD_INDEX, 8'd0, ROT_W'(k), 8'd1, '0);
    issue_word(FUNC_QUERY, 8'd0, 3'd7, 8'hFF, '1);
    issue_word(FUNC_UNUSED, 8'hFF, 3'd7, 8'hFF, '1);
    issue_word(FUNC_QUERY, 8'd72, 3'd0, 8'd0, '0);
    issue_word(FUNC_QUERY, 8'hFF, 3'd0, 8'd0, '0);
    // Zero and one-past-the-end positions fault; the last valid one does not.
    issue_word(FUNC_STORE_GRAD, 8'd71, 3'd6, 8'd0, 32'sh7FFF_FFFF);
    issue_word(FUNC_LOAD_INDEX, 8'd0, 3'd3, 8'd0, '0);
    issue_word(FUNC_LOAD_INDEX, 8'd0, 3'd5, 8'd73, '0);
    issue_word(FUNC_LOAD_INDEX, 8'd0, 3'd6, 8'd72, '0);
    issue_word(FUNC_QUERY, 8'd0, 3'd0, 8'd0, '0);
    settle_block();
  endtask

  // Sweep of entry and rotation counts, saturating and zero values among them.
  task automatic test_config_sweep();
    logic [CFG_DATA_W-1:0] ecnt  [8] = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd300, 9'd5,
                                          9'd255, 9'd72};
    logic [CFG_DATA_W-1:0] rdata [8] = '{9'd1, 9'd8, 9'd3, 9'h1FF, 9'd0, 9'd9,
                                          9'h1E4, 9'd8};
    for (int i = 0; i < 8; i++) begin
      apply_setting(ecnt[i], rdata[i]);
      random_burst(45);
    end
  endtask

  // Bulk traffic with a new random setting every phase.
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] ecnt;
    while (words_sent < 900) begin
      if ($urandom_range(0, 4) != 0) ecnt = CFG_DATA_W'($urandom_range(1, 256));
      else ecnt = CFG_DATA_W'($urandom_range(0, 511));
      apply_setting(ecnt, CFG_DATA_W'($urandom_range(0, 15)));
      random_burst(110);
    end
  endtask

  // Long result stall while queries keep coming, so the input backs up.
  task automatic test_backpressure();
    logic [ENT_W-1:0] ents [4];
    apply_setting(9'd64, 9'd8);
    for (int i = 0; i < 4; i++) begin
      ents[i] = ENT_W'($urandom_range(0, 63));
      gather_sequence(ents[i]);
    end
    settle_block();
    calm     = 1'b1;
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < 24; i++)
      issue_word(FUNC_QUERY, ents[i % 4], ROT_W'($urandom), IDX_W'($urandom), $urandom);
    calm = 1'b0;
    settle_block();
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_closing_stream();
    apply_setting(9'd256, 9'd8);
    calm = 1'b1;
    random_burst(1060 - words_sent);
    settle_block();
  endtask

  // Receiver: random stall bursts, one long hold on request, none when calm.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result check against the oldest expected sum.
  always @(posedge clk_i) begin
    gather_t exp_sum;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected result, actual sum %0d entry %0d fault %0b",
                 $time, grad_sum_o, query_entry_o, index_fault_o);
        error_count++;
      end else begin
        exp_sum = sums_due.pop_front();
        if (grad_sum_o !== exp_sum.grad_sum) begin
          $display("%0t: grad_sum expected %0d actual %0d", $time,
                   exp_sum.grad_sum, grad_sum_o);
          error_count++;
        end
        if (query_entry_o !== exp_sum.query_entry) begin
          $display("%0t: query_entry expected %0d actual %0d", $time,
                   exp_sum.query_entry, query_entry_o);
          error_count++;
        end
        if (index_fault_o !== exp_sum.index_fault) begin
          $display("%0t: index_fault expected %0b actual %0b", $time,
                   exp_sum.index_fault, index_fault_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("tb_rotation_gradient_gather_sum: errors");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_basics();
    test_config_sweep();
    test_random_traffic();
    test_backpressure();
    test_closing_stream();
    if (error_count == 0 && sums_due.size() == 0) begin
      $display("tb_rotation_gradient_gather_sum: clean");
    end else begin
      $display("tb_rotation_gradient_gather_sum: errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rggs_pkg.sv
rtl/rggs_front.sv
rtl/rggs_queue.sv
rtl/rggs_back.sv
rtl/rotation_gradient_gather_sum.sv
tb/sv/tb_rotation_gradient_gather_sum.sv
